FILE: rtl/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and constants for the millisecond calendar clock
// Holds the sequencer states, calendar tables and fixed arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cmc_pkg;

  localparam int RATE_W    = 20;
  localparam int DIVIDEND_W = 42;
  localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);
  localparam int DAYS_W    = 22;

  localparam logic [RATE_W-1:0] RATE_RESET  = 20'd1000;
  localparam logic [13:0]       YEAR_MAX    = 14'd9999;
  localparam logic [31:0]       MS_PER_DAY  = 32'd86400000;
  localparam logic [31:0]       MS_PER_HOUR = 32'd3600000;
  localparam logic [31:0]       MS_PER_MIN  = 32'd60000;
  localparam logic [31:0]       MS_PER_SEC  = 32'd1000;
  localparam logic [31:0]       DAYS_PER_YEAR = 32'd365;
  // floor(y / 100) equals (y * 5243) >> 19 for every 14-bit y.
  localparam logic [31:0]       RECIP_100   = 32'd5243;
  localparam int                RECIP_SHIFT = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q100,
    ST_CHECK,
    ST_DAYS,
    ST_DMS,
    ST_HR,
    ST_MIN,
    ST_SEC,
    ST_SFIN,
    ST_RDMUL,
    ST_DIVST,
    ST_DIVW,
    ST_RDADD,
    ST_OUT
  } state_t;

  // Days before the first of the given month (0 = January).
  function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    begin
      case (idx)
        4'd0:    d = 9'd0;
        4'd1:    d = 9'd31;
        4'd2:    d = 9'd59;
        4'd3:    d = 9'd90;
        4'd4:    d = 9'd120;
        4'd5:    d = 9'd151;
        4'd6:    d = 9'd181;
        4'd7:    d = 9'd212;
        4'd8:    d = 9'd243;
        4'd9:    d = 9'd273;
        4'd10:   d = 9'd304;
        4'd11:   d = 9'd334;
        default: d = 9'd0;
      endcase
      if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
        d = d + 9'd1;
      end
      return d;
    end
  endfunction

  // Length of a month, 1 = January; zero for months that do not exist.
  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    begin
      case (mon)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
        4'd2:    d = leap ? 5'd29 : 5'd28;
        default: d = 5'd0;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmc_divider.sv
// ----------------------------------------------------------------------------
// cmc_divider: restoring divider, one quotient bit per cycle
// Divides the scaled tick delta by the tick rate; the remainder is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module cmc_divider
  import cmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [RATE_W-1:0]     divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W:0]      shifted;
  logic                 fits;

  // Bring down the next dividend bit and try a subtraction.
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? RATE_W'(shifted - {1'b0, dvs}) : shifted[RATE_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/calendar_millisecond_clock_unit.sv
// A set word runs the sequencer from ST_Q100 through ST_SFIN to ST_OUT; a
// rejected set goes from ST_CHECK straight to ST_OUT. A read word runs
// ST_RDMUL, ST_DIVST, ST_DIVW (the one-bit-per-cycle tick-rate divider),
// ST_RDADD and ST_OUT. One word is in the sequencer at a time: a new word is
// taken only in ST_IDLE, and an output stall holds the sequencer in ST_OUT.
// Synchronous reset clears the clock to zero, the stored tick to zero and the
// tick rate to 1000 Hz; no clearing pass is needed.
// ----------------------------------------------------------------------------
// calendar_millisecond_clock_unit: millisecond wall clock on a Gregorian date
// Loads a 64-bit millisecond count from a date and time, and advances it from
// a free-running tick counter on each read.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_millisecond_clock_unit
  import cmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Tick-rate register write port.
  input  wire logic              cfg_wr_en,
  input  wire logic [RATE_W-1:0] cfg_wr_data,
  // Request channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic [13:0]       year,
  input  wire logic [3:0]        month,
  input  wire logic [4:0]        day,
  input  wire logic [4:0]        hour,
  input  wire logic [5:0]        minute,
  input  wire logic [5:0]        second,
  input  wire logic [31:0]       tick_now,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [63:0]            timestamp_ms,
  output logic                   status
);

  // All multiplications but q100*100 go through one 32x32 multiplier whose
  // product is registered every cycle; the sequencer picks its operands.
  // A set runs: year/100 by reciprocal, field check and leap year, days
  // before the year by prev*365 plus the leap corrections, then days, hours,
  // minutes and seconds scaled to milliseconds and accumulated.
  // A read runs: delta*1000 on the multiplier, then the serial divider.

  state_t state, state_next;

  logic [RATE_W-1:0] tick_rate_hz;
  logic [63:0]       running_ms;
  logic [31:0]       last_tick;

  // Captured request word.
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [31:0] tick_r;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // Date arithmetic.
  logic [7:0]        q100;
  logic [7:0]        q100_r;
  logic [13:0]       rem100;
  logic              div100, div400, leap;
  logic              div100_r, div400_r, leap_r;
  logic              date_ok;
  logic [13:0]       elapsed_years;
  logic [DAYS_W-1:0] days;
  logic [DAYS_W-1:0] days_calc;
  logic [63:0]       acc;
  logic [63:0]       acc_sum;

  // Result held until the output register is free.
  logic [63:0] res_ms;
  logic        res_status;

  // Divider.
  logic                  div_start;
  logic                  div_busy;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [RATE_W-1:0]     div_divisor;

  logic in_take;
  logic out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // A zero rate behaves as one tick per second.
  assign div_divisor = (tick_rate_hz == '0) ? RATE_W'(1) : tick_rate_hz;
  assign div_start   = (state == ST_DIVST);

  assign elapsed_years = year_r - 14'd1;
  assign acc_sum       = acc + prod;

  cmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIVIDEND_W-1:0]),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Leap year and field checks, valid while the year/100 product is present.
  always_comb begin
    q100    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    rem100  = year_r - (14'(q100) * 14'd100);
    div100  = (rem100 == 14'd0);
    div400  = div100 && (q100[1:0] == 2'b00);
    leap    = (year_r[1:0] == 2'b00) && (!div100 || div400);
    date_ok = (year_r >= 14'd1) && (year_r <= YEAR_MAX) &&
              (day_r >= 5'd1) && (day_r <= days_in_month(month_r, leap)) &&
              (hour_r <= 5'd23) && (minute_r <= 6'd59) && (second_r <= 6'd59);
  end

  // Days since 0001-01-01: prev*365 + prev/4 - prev/100 + prev/400 plus the
  // days elapsed in this year. prev/100 and prev/400 follow from year/100,
  // less one when the year itself is a multiple.
  always_comb begin
    days_calc = prod[DAYS_W-1:0]
              + DAYS_W'(elapsed_years >> 2)
              - DAYS_W'(q100_r) + DAYS_W'(div100_r)
              + DAYS_W'(q100_r >> 2) - DAYS_W'(div400_r)
              + DAYS_W'(cum_days(month_r - 4'd1, leap_r))
              + DAYS_W'(day_r) - DAYS_W'(1);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_Q100: begin
        mul_a = 32'(year_r);
        mul_b = RECIP_100;
      end
      ST_CHECK: begin
        mul_a = 32'(elapsed_years);
        mul_b = DAYS_PER_YEAR;
      end
      ST_DMS: begin
        mul_a = 32'(days);
        mul_b = MS_PER_DAY;
      end
      ST_HR: begin
        mul_a = 32'(hour_r);
        mul_b = MS_PER_HOUR;
      end
      ST_MIN: begin
        mul_a = 32'(minute_r);
        mul_b = MS_PER_MIN;
      end
      ST_SEC: begin
        mul_a = 32'(second_r);
        mul_b = MS_PER_SEC;
      end
      ST_RDMUL: begin
        mul_a = tick_r - last_tick;
        mul_b = MS_PER_SEC;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = action ? ST_RDMUL : ST_Q100;
        end
      end
      ST_Q100:  state_next = ST_CHECK;
      ST_CHECK: state_next = date_ok ? ST_DAYS : ST_OUT;
      ST_DAYS:  state_next = ST_DMS;
      ST_DMS:   state_next = ST_HR;
      ST_HR:    state_next = ST_MIN;
      ST_MIN:   state_next = ST_SEC;
      ST_SEC:   state_next = ST_SFIN;
      ST_SFIN:  state_next = ST_OUT;
      ST_RDMUL: state_next = ST_DIVST;
      ST_DIVST: state_next = ST_DIVW;
      ST_DIVW: begin
        if (!div_busy) begin
          state_next = ST_RDADD;
        end
      end
      ST_RDADD: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Request capture and datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      year_r   <= year;
      month_r  <= month;
      day_r    <= day;
      hour_r   <= hour;
      minute_r <= minute;
      second_r <= second;
      tick_r   <= tick_now;
    end
    case (state)
      ST_CHECK: begin
        q100_r   <= q100;
        div100_r <= div100;
        div400_r <= div400;
        leap_r   <= leap;
        res_ms     <= '0;
        res_status <= 1'b1;
      end
      ST_DAYS: days <= days_calc;
      ST_HR:   acc  <= prod;
      ST_MIN:  acc  <= acc_sum;
      ST_SEC:  acc  <= acc_sum;
      ST_SFIN: begin
        res_ms     <= acc_sum;
        res_status <= 1'b0;
      end
      ST_RDADD: begin
        res_ms     <= running_ms + 64'(div_quo);
        res_status <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Architectural state: clock, last tick and tick rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_ms   <= '0;
      last_tick    <= '0;
      tick_rate_hz <= RATE_RESET;
    end else begin
      if (cfg_wr_en) begin
        tick_rate_hz <= cfg_wr_data;
      end
      if (state == ST_SFIN) begin
        running_ms <= acc_sum;
        last_tick  <= tick_r;
      end else if (state == ST_RDADD) begin
        running_ms <= running_ms + 64'(div_quo);
        last_tick  <= tick_r;
      end
    end
  end

  // Output register; a new word may be accepted while it waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      timestamp_ms <= res_ms;
      status       <= res_status;
    end
  end

endmodule

`default_nettype wire
